### hw/rtl/sdg_pkg.sv
// Shared constants, tables and types for the shortest decimal digit generator.
package sdg_pkg;

  localparam int unsigned FracW     = 64;
  localparam int unsigned MpExpW    = 7;
  localparam int unsigned DecExpW   = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CountW    = 6;
  localparam int unsigned KappaW    = 7;
  localparam int unsigned ShiftW    = 6;
  localparam int unsigned IntW      = 32;
  localparam int unsigned MultW     = 34;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned IntDigits = 10;
  localparam int unsigned Radix     = 10;

  localparam int unsigned MaxDigits = 32;
  localparam int unsigned ResLimit  = 32;
  localparam int unsigned DigitCap  = (MaxDigits < ResLimit) ? MaxDigits : ResLimit;

  localparam int MpExpMin = -60;
  localparam int MpExpMax = -32;

  localparam logic [MultW-1:0] TopPlace = MultW'(64'd1000000000);

  typedef logic [Radix-1:0][MultW-1:0] mult_row_t;
  typedef logic [IntDigits-1:0][Radix-1:0][MultW-1:0] mult_tbl_t;

  // Row i holds j * 10^i for j = 0..9.
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t         t;
    logic [MultW-1:0]  p;
    p = MultW'(1);
    for (int i = 0; i < IntDigits; i++) begin
      for (int j = 0; j < Radix; j++) begin
        t[i][j] = MultW'(j) * p;
      end
      p = p * MultW'(Radix);
    end
    return t;
  endfunction

  localparam mult_tbl_t MultTbl = build_mult_tbl();

  typedef enum logic [1:0] {
    StIdle,
    StFirst,
    StRun
  } sdg_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } sdg_cmd_t;

  typedef struct packed {
    logic stop;
    logic out_free;
  } sdg_stat_t;

endpackage

### hw/rtl/sdg_in_if.sv
// Request channel carrying one scaled value and its error allowance.
interface sdg_in_if import sdg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FracW-1:0]          mp_frac;
  logic signed [MpExpW-1:0]  mp_exp;
  logic [FracW-1:0]          delta_frac;
  logic signed [DecExpW-1:0] exponent_in;

  modport source (output valid, mp_frac, mp_exp, delta_frac, exponent_in, input ready);
  modport sink   (input valid, mp_frac, mp_exp, delta_frac, exponent_in, output ready);
endinterface

### hw/rtl/sdg_out_if.sv
// Result channel carrying one decimal digit per transfer.
interface sdg_out_if import sdg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DigitW-1:0]         digit;
  logic                      digit_valid;
  logic                      last;
  logic [CountW-1:0]         digit_count;
  logic signed [DecExpW-1:0] exponent_out;
  logic                      truncated;

  modport source (output valid, digit, digit_valid, last, digit_count, exponent_out,
                  truncated, input ready);
  modport sink   (input valid, digit, digit_valid, last, digit_count, exponent_out,
                  truncated, output ready);
endinterface

### hw/rtl/shortest_decimal_digit_gen_top.sv
// Top level of the shortest decimal digit generator.
//
// Each request carries a 64-bit mantissa, a binary exponent clamped to -60 to -32, an error
// allowance on the fraction scale and a decimal exponent. The block returns the decimal
// digits of the value, most significant first and without leading zeros, one result per
// digit, stopping as soon as the remainder lies within the allowance or after 32 digits;
// the final result carries the adjusted exponent and the truncation flag, and a run that
// yields no digit returns a single empty final result. One decimal place (integer or
// fractional, leading zeros included) is examined per cycle by a shared digit step while
// the output register is free; a request examines at most ten integer places and up to
// about fifty fractional places. The next request is taken once the final result
// has been written to the output register; the step stalls while that register is full.
module shortest_decimal_digit_gen_top import sdg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdg_in_if.sink    req_i,
  sdg_out_if.source rsp_o
);

  sdg_cmd_t  cmd;
  sdg_stat_t stat;

  sdg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sdg_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

### hw/rtl/sdg_ctrl.sv
// Controller state machine sequencing load, digit steps and the final result.
module sdg_ctrl import sdg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdg_in_if.sink    req_i,
  input  sdg_stat_t stat_i,
  output sdg_cmd_t  cmd_o
);

  sdg_state_e state_q, state_d;
  logic       in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready = 1'b1;
        if (req_i.valid) begin
          cmd_o.load = 1'b1;
          state_d    = StFirst;
        end
      end
      StFirst: begin
        cmd_o.step = 1'b1;
        state_d    = StRun;
      end
      StRun: begin
        if (stat_i.out_free) begin
          if (stat_i.stop) begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign req_i.ready = in_ready;

endmodule

### hw/rtl/sdg_datapath.sv
// Digit extraction, stop check, exponent adjustment and result register.
module sdg_datapath import sdg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdg_in_if.sink    req_i,
  sdg_out_if.source rsp_o,
  input  sdg_cmd_t  cmd_i,
  output sdg_stat_t stat_o
);

  logic [IntW-1:0]          p1_q;
  logic [FracW-1:0]         p2_q;
  logic [FracW-1:0]         delta_q;
  logic [ShiftW-1:0]        shift_q;
  logic signed [KappaW-1:0] kappa_q;
  logic [CountW-1:0]        count_q;
  logic [DigitW-1:0]        pend_q;
  logic                     pend_valid_q;
  logic signed [DecExpW-1:0] exp_q;

  logic                      out_valid_q;
  logic [DigitW-1:0]         out_digit_q;
  logic                      out_dvalid_q;
  logic                      out_last_q;
  logic [CountW-1:0]         out_count_q;
  logic signed [DecExpW-1:0] out_exp_q;
  logic                      out_trunc_q;

  logic [ShiftW-1:0] shift_ld;
  logic [FracW-1:0]  mask_ld;
  logic [FracW-1:0]  mask;
  logic              int_phase;
  logic [IdxW-1:0]   tbl_idx;
  mult_row_t         row;
  logic [DigitW-1:0] d_int;
  logic [IntW-1:0]   p1_next;
  logic [FracW-1:0]  p2x;
  logic [DigitW-1:0] d_frac;
  logic [FracW-1:0]  delta_next;
  logic [DigitW-1:0] step_digit;
  logic              digit_new;
  logic [FracW-1:0]  int_rem;
  logic              chk;
  logic signed [DecExpW:0]   exp_sum;
  logic signed [DecExpW-1:0] exp_sat;
  logic              out_we;

  // Clamp the binary exponent and turn it into the fraction bit count.
  always_comb begin
    if (req_i.mp_exp < MpExpMin) begin
      shift_ld = ShiftW'(-MpExpMin);
    end else if (req_i.mp_exp > MpExpMax) begin
      shift_ld = ShiftW'(-MpExpMax);
    end else begin
      shift_ld = ShiftW'(-req_i.mp_exp);
    end
  end

  assign mask_ld = (FracW'(1) << shift_ld) - FracW'(1);
  assign mask    = (FracW'(1) << shift_q) - FracW'(1);

  // Integer places are taken while kappa is positive.
  assign int_phase = !kappa_q[KappaW-1] && (kappa_q != '0);
  assign tbl_idx   = int_phase ? (IdxW'(kappa_q) - IdxW'(1)) : '0;
  assign row       = MultTbl[tbl_idx];

  always_comb begin
    d_int = '0;
    for (int j = 1; j < Radix; j++) begin
      if ({{(MultW-IntW){1'b0}}, p1_q} >= row[j]) begin
        d_int = DigitW'(j);
      end
    end
  end

  assign p1_next    = p1_q - row[d_int][IntW-1:0];
  assign p2x        = (p2_q << 3) + (p2_q << 1);
  assign d_frac     = DigitW'(p2x >> shift_q);
  assign delta_next = (delta_q << 3) + (delta_q << 1);
  assign step_digit = int_phase ? d_int : d_frac;
  assign digit_new  = (step_digit != '0) || (count_q != '0);

  // The check belongs to the place just taken: integer form while kappa is not negative.
  assign int_rem = ({{(FracW-IntW){1'b0}}, p1_q} << shift_q) + p2_q;
  assign chk     = kappa_q[KappaW-1] ? (p2_q <= delta_q) : (int_rem <= delta_q);

  assign stat_o.stop     = chk || (count_q >= CountW'(DigitCap));
  assign stat_o.out_free = !out_valid_q || rsp_o.ready;

  assign exp_sum = {exp_q[DecExpW-1], exp_q}
                 + {{(DecExpW + 1 - KappaW){kappa_q[KappaW-1]}}, kappa_q};
  assign exp_sat = (exp_sum[DecExpW] != exp_sum[DecExpW-1])
                 ? {exp_sum[DecExpW], {(DecExpW-1){~exp_sum[DecExpW]}}}
                 : exp_sum[DecExpW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p1_q         <= IntW'(req_i.mp_frac >> shift_ld);
      p2_q         <= req_i.mp_frac & mask_ld;
      delta_q      <= req_i.delta_frac;
      shift_q      <= shift_ld;
      kappa_q      <= KappaW'(IntDigits);
      count_q      <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      exp_q        <= req_i.exponent_in;
    end else if (cmd_i.step) begin
      if (int_phase) begin
        p1_q <= p1_next;
      end else begin
        p2_q    <= p2x & mask;
        delta_q <= delta_next;
      end
      kappa_q      <= kappa_q - KappaW'(1);
      pend_q       <= step_digit;
      pend_valid_q <= digit_new;
      count_q      <= count_q + CountW'(digit_new);
    end
  end

  assign out_we = cmd_i.finish || (cmd_i.step && pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_we) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_digit_q  <= pend_valid_q ? pend_q : '0;
      out_dvalid_q <= pend_valid_q;
      out_last_q   <= cmd_i.finish;
      out_count_q  <= count_q;
      out_exp_q    <= cmd_i.finish ? exp_sat : '0;
      out_trunc_q  <= cmd_i.finish && !chk;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.digit        = out_digit_q;
  assign rsp_o.digit_valid  = out_dvalid_q;
  assign rsp_o.last         = out_last_q;
  assign rsp_o.digit_count  = out_count_q;
  assign rsp_o.exponent_out = out_exp_q;
  assign rsp_o.truncated    = out_trunc_q;

endmodule

### test/tb_top.sv
// Self-checking testbench for the shortest decimal digit generator top level.
module tb_top import sdg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 160;
  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 4000;
  localparam int TailCycles  = 200;
  localparam int MaxPrints   = 40;
  localparam int TxIdlePct [3] = '{29, 66, 0};
  localparam int RxIdlePct [3] = '{66, 29, 0};

  typedef struct packed {
    logic [FracW-1:0]          mp_frac;
    logic signed [MpExpW-1:0]  mp_exp;
    logic [FracW-1:0]          delta_frac;
    logic signed [DecExpW-1:0] exponent_in;
  } sdg_req_t;

  typedef struct packed {
    logic [DigitW-1:0]         digit;
    logic                      digit_valid;
    logic                      last;
    logic [CountW-1:0]         digit_count;
    logic signed [DecExpW-1:0] exponent_out;
    logic                      truncated;
  } digit_res_t;

  typedef struct {
    sdg_req_t req;
    int       phase;
    bit       drain;
    bit       hold;
  } pending_t;

  logic clk_i;
  logic rst_ni;

  sdg_in_if  req_if ();
  sdg_out_if rsp_if ();

  shortest_decimal_digit_gen_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pending_t    pending_requests [$];
  digit_res_t  expected_digits [$];
  int unsigned items_queued;
  int          drv_phase;
  logic        cur_hold;
  logic        results_drained;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned requests_seen;
  int unsigned results_seen;
  int unsigned capped_runs;
  int unsigned empty_runs;

  task automatic flag_mismatch(input string msg);
    if (mismatches < MaxPrints) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d field %s got 0x%h expected 0x%h",
                              results_seen, name, got, want));
    end
  endtask

  function automatic void predict_digits(input sdg_req_t r);
    logic [FracW-1:0]  p2;
    logic [FracW-1:0]  mask;
    logic [FracW-1:0]  allow;
    logic [FracW-1:0]  rem;
    logic [IntW-1:0]   p1;
    logic [IntW-1:0]   place;
    logic [IntW-1:0]   d;
    logic [DigitW-1:0] digs [DigitCap];
    int                e;
    int                s;
    int                kappa;
    int                n;
    int                eo;
    bit                trunc;
    bit                done;
    digit_res_t        res;
    e = int'(r.mp_exp);
    if (e < MpExpMin) e = MpExpMin;
    if (e > MpExpMax) e = MpExpMax;
    s = -e;
    mask = (64'd1 << s) - 64'd1;
    p1 = IntW'(r.mp_frac >> s);
    p2 = r.mp_frac & mask;
    allow = r.delta_frac;
    kappa = IntDigits;
    place = IntW'(TopPlace);
    n = 0;
    trunc = 1'b0;
    done = 1'b0;
    while (kappa > 0 && !done) begin
      d = p1 / place;
      if (d != 0 || n != 0) begin
        digs[n] = d[DigitW-1:0];
        n++;
      end
      p1 = p1 % place;
      kappa--;
      place = place / Radix;
      rem = (FracW'(p1) << s) + p2;
      if (rem <= allow) begin
        done = 1'b1;
      end else if (n >= int'(DigitCap)) begin
        trunc = 1'b1;
        done = 1'b1;
      end
    end
    while (!done) begin
      p2 = p2 * FracW'(Radix);
      d = IntW'(p2 >> s);
      if (d != 0 || n != 0) begin
        digs[n] = d[DigitW-1:0];
        n++;
      end
      p2 = p2 & mask;
      kappa--;
      allow = allow * FracW'(Radix);
      if (p2 <= allow) begin
        done = 1'b1;
      end else if (n >= int'(DigitCap)) begin
        trunc = 1'b1;
        done = 1'b1;
      end
    end
    eo = int'(r.exponent_in) + kappa;
    if (eo < -512) eo = -512;
    if (eo > 511) eo = 511;
    if (trunc) capped_runs++;
    if (n == 0) begin
      empty_runs++;
      res = '0;
      res.last = 1'b1;
      res.exponent_out = DecExpW'(eo);
      res.truncated = trunc;
      expected_digits.push_back(res);
    end else begin
      for (int k = 0; k < n; k++) begin
        res = '0;
        res.digit = digs[k];
        res.digit_valid = 1'b1;
        res.last = (k == n - 1);
        res.digit_count = CountW'(k + 1);
        if (k == n - 1) begin
          res.exponent_out = DecExpW'(eo);
          res.truncated = trunc;
        end
        expected_digits.push_back(res);
      end
    end
  endfunction

  task automatic add_request(input logic [FracW-1:0] frac, input logic signed [MpExpW-1:0] e,
                             input logic [FracW-1:0] delta,
                             input logic signed [DecExpW-1:0] k_in, input int phase,
                             input bit drain, input bit hold);
    pending_t p;
    p.req.mp_frac = frac;
    p.req.mp_exp = e;
    p.req.delta_frac = delta;
    p.req.exponent_in = k_in;
    p.phase = phase;
    p.drain = drain;
    p.hold = hold;
    pending_requests.push_back(p);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : drive_requests
    pending_t nxt;
    bit       offer;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      cur_hold <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      offer = 1'b0;
      if (pending_requests.size() != 0) begin
        nxt = pending_requests[0];
        offer = $urandom_range(99) >= TxIdlePct[nxt.phase];
        if (nxt.drain && (!results_drained || req_if.valid)) offer = 1'b0;
      end
      if (offer) begin
        void'(pending_requests.pop_front());
        req_if.valid <= 1'b1;
        req_if.mp_frac <= nxt.req.mp_frac;
        req_if.mp_exp <= nxt.req.mp_exp;
        req_if.delta_frac <= nxt.req.delta_frac;
        req_if.exponent_in <= nxt.req.exponent_in;
        cur_hold <= nxt.hold;
        drv_phase <= nxt.phase;
      end else begin
        req_if.valid <= 1'b0;
        cur_hold <= 1'b0;
      end
      items_queued <= pending_requests.size();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (req_if.valid && req_if.ready && cur_hold) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watch_results
    digit_res_t want;
    sdg_req_t   seen;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      results_drained <= 1'b1;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_digits.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_digits.pop_front();
          check_field("digit", 16'(rsp_if.digit), 16'(want.digit));
          check_field("digit_valid", 16'(rsp_if.digit_valid), 16'(want.digit_valid));
          check_field("last", 16'(rsp_if.last), 16'(want.last));
          check_field("digit_count", 16'(rsp_if.digit_count), 16'(want.digit_count));
          check_field("exponent_out", 16'(rsp_if.exponent_out), 16'(want.exponent_out));
          check_field("truncated", 16'(rsp_if.truncated), 16'(want.truncated));
        end
        results_seen++;
      end
      if (req_if.valid && req_if.ready) begin
        seen.mp_frac = req_if.mp_frac;
        seen.mp_exp = req_if.mp_exp;
        seen.delta_frac = req_if.delta_frac;
        seen.exponent_in = req_if.exponent_in;
        predict_digits(seen);
        requests_seen++;
      end
      results_drained <= (expected_digits.size() == 0);
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= RxIdlePct[drv_phase]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no transfer for %0d cycles", QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [FracW-1:0]          frac;
    logic signed [MpExpW-1:0]  e;
    logic [FracW-1:0]          delta;
    logic signed [DecExpW-1:0] k_in;
    int                        phase;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.mp_frac = '0;
    req_if.mp_exp = '0;
    req_if.delta_frac = '0;
    req_if.exponent_in = '0;
    rsp_if.ready = 1'b0;
    cur_hold = 1'b0;
    drv_phase = 0;
    results_drained = 1'b1;
    mismatches = 0;
    requests_seen = 0;
    results_seen = 0;
    capped_runs = 0;
    empty_runs = 0;

    add_request(64'd0, -7'sd32, 64'd0, 10'sd0, 0, 0, 0);
    add_request('1, -7'sd32, 64'd0, 10'sd0, 0, 0, 0);
    add_request('1, -7'sd60, '1, 10'sd400, 0, 0, 0);
    add_request('1, -7'sd60, 64'd0, -10'sd400, 0, 0, 0);
    add_request(64'd1000000000 << 32, -7'sd32, 64'd0, 10'sd7, 0, 0, 0);
    add_request(64'd1 << 32, -7'sd32, 64'd0, -10'sd3, 0, 0, 0);
    add_request(64'h8000_0000_0000_0000, -7'sd60, 64'd0, 10'sd1, 0, 0, 0);
    add_request(64'd1, -7'sd60, 64'd0, -10'sd512, 0, 0, 0);
    add_request(64'd0, -7'sd32, 64'd0, 10'sd511, 0, 0, 0);
    add_request(64'h0123_4567_89AB_CDEF, -7'sd64, 64'h0000_0000_0010_0000, 10'sd5, 0, 0, 0);
    add_request(64'h0123_4567_89AB_CDEF, 7'sd63, 64'h0000_0000_0010_0000, 10'sd5, 0, 0, 0);
    add_request(64'hFEDC_BA98_7654_3210, 7'sd0, 64'd1000, -10'sd20, 0, 0, 0);
    add_request(64'hFEDC_BA98_7654_3210, -7'sd1, 64'd1000, 10'sd20, 0, 0, 0);
    add_request(64'h0F00_0000_0000_0001, -7'sd61, 64'd77, 10'sd0, 0, 0, 0);
    add_request(64'h0000_7FFF_FFFF_FFFF, -7'sd31, 64'd5, 10'sd0, 0, 0, 0);
    add_request((64'd5 << 32) | 64'd123, -7'sd32, 64'd123, 10'sd0, 0, 0, 0);
    add_request((64'd5 << 32) | 64'd123, -7'sd32, 64'd122, 10'sd0, 0, 0, 0);
    add_request(64'h8000_0000_0000_0000, -7'sd40, 64'h8000_0000_0000_0000, 10'sd100, 0, 0, 0);
    add_request(64'h0FFF_FFFF_FFFF_FFFF, -7'sd60, 64'h0000_0000_0000_FFFF, -10'sd100, 0, 0, 0);
    add_request(64'd12345 << 40, -7'sd40, 64'd1 << 38, 10'sd0, 0, 0, 0);
    add_request('1, -7'sd45, 64'd1, 10'sd511, 0, 0, 0);

    for (int i = 0; i < RandomItems; i++) begin
      phase = (i * 3) / RandomItems;
      frac = {$urandom, $urandom};
      if ($urandom_range(3) == 0) frac = frac >> $urandom_range(63);
      if ($urandom_range(15) == 0) begin
        e = MpExpW'($urandom);
      end else begin
        e = MpExpW'(-int'($urandom_range(60, 32)));
      end
      case ($urandom_range(7))
        0: delta = '0;
        1: delta = '1;
        default: delta = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      if ($urandom_range(9) == 0) begin
        k_in = DecExpW'($urandom);
      end else begin
        k_in = DecExpW'(int'($urandom_range(800)) - 400);
      end
      add_request(frac, e, delta, k_in, phase, (i == 60 || i == 120),
                  (i == 30 || i == 150));
    end
    items_queued = pending_requests.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (items_queued != 0 || req_if.valid || !results_drained);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_digits.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", expected_digits.size()));
    end

    $display("Summary: %0d requests and %0d digit results checked; %0d runs hit the cap,",
             requests_seen, results_seen, capped_runs);
    $display("  %0d runs gave no digit, under alternating backpressure and a %0d-cycle hold-off.",
             empty_runs, HoldCycles);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
